@@ sv/mas_pkg.sv @@
// Shared constants, codes and types of the minimization arm assigner.
package mas_pkg;

   localparam int MAX_LEVELS     = 64;
   localparam int MAX_COVARIATES = 4;
   localparam int COUNT_BITS     = 16;
   localparam int LEVEL_FIELDS   = 4;

   localparam int COV_LIMIT  = (MAX_COVARIATES < LEVEL_FIELDS) ? MAX_COVARIATES : LEVEL_FIELDS;
   localparam int LEVEL_W    = 6;
   localparam int ROW_ADDR_W = $clog2(MAX_LEVELS);
   localparam int ROW_W      = 2 * COUNT_BITS;
   localparam int COV_IDX_W  = $clog2(LEVEL_FIELDS);
   localparam int NCOV_W     = 3;
   localparam int NLEV_W     = 7;
   localparam int WEIGHT_W   = 16;
   localparam int PROB_W     = 17;
   localparam int DRAW_W     = 16;
   localparam int FUNC_W     = 2;
   localparam int DIFF_W     = COUNT_BITS + 1;
   localparam int PROD_W     = DIFF_W + WEIGHT_W + 1;
   localparam int SCORE_W    = PROD_W + COV_IDX_W + 1;

   localparam int REQ_BITS   = FUNC_W + LEVEL_FIELDS * LEVEL_W + DRAW_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = 3;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_WEIGHT_0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WEIGHT_1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WEIGHT_2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WEIGHT_3 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BEST     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIE      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_NCOV     = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_NLEV     = 3'd7;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
   localparam logic [PROB_W-1:0]   BEST_RESET   = 17'd49152;
   localparam logic [PROB_W-1:0]   TIE_RESET    = 17'd32768;
   localparam logic [NCOV_W-1:0]   NCOV_RESET   = 3'd4;
   localparam logic [NLEV_W-1:0]   NLEV_RESET   = 7'd64;

   typedef struct packed {
      logic [LEVEL_FIELDS-1:0][WEIGHT_W-1:0] weight;
      logic [PROB_W-1:0]                     best_prob;
      logic [PROB_W-1:0]                     tie_prob;
      logic [NCOV_W-1:0]                     ncov;
      logic [NLEV_W-1:0]                     nlev;
   } cfg_type;

endpackage

@@ sv/mas_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/mas_csr.sv @@
// Configuration registers of the minimization arm assigner.
module mas_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mas_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [mas_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output mas_pkg::cfg_type                 cfg
);

   mas_pkg::cfg_type cfg_ff;
   mas_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            mas_pkg::CSR_WEIGHT_0: cfg_in.weight[0] = csr_wdata[mas_pkg::WEIGHT_W-1:0];
            mas_pkg::CSR_WEIGHT_1: cfg_in.weight[1] = csr_wdata[mas_pkg::WEIGHT_W-1:0];
            mas_pkg::CSR_WEIGHT_2: cfg_in.weight[2] = csr_wdata[mas_pkg::WEIGHT_W-1:0];
            mas_pkg::CSR_WEIGHT_3: cfg_in.weight[3] = csr_wdata[mas_pkg::WEIGHT_W-1:0];
            mas_pkg::CSR_BEST:     cfg_in.best_prob = csr_wdata[mas_pkg::PROB_W-1:0];
            mas_pkg::CSR_TIE:      cfg_in.tie_prob  = csr_wdata[mas_pkg::PROB_W-1:0];
            mas_pkg::CSR_NCOV:     cfg_in.ncov      = csr_wdata[mas_pkg::NCOV_W-1:0];
            mas_pkg::CSR_NLEV:     cfg_in.nlev      = csr_wdata[mas_pkg::NLEV_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mas_pkg::LEVEL_FIELDS; i++) begin
            cfg_ff.weight[i] <= mas_pkg::WEIGHT_RESET;
         end
         cfg_ff.best_prob <= mas_pkg::BEST_RESET;
         cfg_ff.tie_prob  <= mas_pkg::TIE_RESET;
         cfg_ff.ncov      <= mas_pkg::NCOV_RESET;
         cfg_ff.nlev      <= mas_pkg::NLEV_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/mas_ctrl.sv @@
// Sequencer: count-table reads, weighted score, arm choice and count write-back.
module mas_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  mas_pkg::cfg_type                   cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mas_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mas_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               mem_we,
   output logic [mas_pkg::ROW_ADDR_W-1:0]     mem_waddr,
   output logic [mas_pkg::ROW_W-1:0]          mem_wdata,
   output logic [mas_pkg::ROW_ADDR_W-1:0]     mem_raddr,
   input  logic [mas_pkg::ROW_W-1:0]          mem_rdata
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;
   localparam logic [3:0] S_MUL    = 4'd3;
   localparam logic [3:0] S_ACC    = 4'd4;
   localparam logic [3:0] S_DECIDE = 4'd5;
   localparam logic [3:0] S_WRD    = 4'd6;
   localparam logic [3:0] S_WMOD   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   localparam int CB = mas_pkg::COUNT_BITS;
   localparam int LW = mas_pkg::LEVEL_W;

   logic [3:0]                             state_ff, state_in;
   logic [mas_pkg::FUNC_W-1:0]             func_ff, func_in;
   logic [LW-1:0]                          lev_ff [mas_pkg::LEVEL_FIELDS];
   logic [LW-1:0]                          lev_in [mas_pkg::LEVEL_FIELDS];
   logic [mas_pkg::DRAW_W-1:0]             draw_ff, draw_in;
   logic [mas_pkg::NCOV_W-1:0]             cnt_ff, cnt_in;
   logic signed [mas_pkg::SCORE_W-1:0]     score_ff, score_in;
   logic signed [mas_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic                                   arm_ff, arm_in;
   logic                                   tie_ff, tie_in;
   logic                                   status_ff, status_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [mas_pkg::RSP_BITS-1:0]           rsp_data_ff, rsp_data_in;
   logic [mas_pkg::MAX_LEVELS-1:0]         valid_ff, valid_in;
   logic                                   rvalid_ff, rvalid_in;

   logic [mas_pkg::NCOV_W-1:0]             ncov;
   logic [mas_pkg::NLEV_W-1:0]             limit;
   logic [mas_pkg::COV_IDX_W-1:0]          idx;
   logic [LW-1:0]                          cur_lev;
   logic [mas_pkg::ROW_ADDR_W-1:0]         row_addr;
   logic [mas_pkg::ROW_W-1:0]              row;
   logic [CB-1:0]                          c0, c1, csel, cinc;
   logic signed [mas_pkg::DIFF_W-1:0]      diff;
   logic                                   bad;
   logic [mas_pkg::NCOV_W-1:0]             cnt_next;
   logic                                   out_free;
   logic                                   best;

   assign ncov  = (cfg.ncov > mas_pkg::NCOV_W'(mas_pkg::COV_LIMIT))
                  ? mas_pkg::NCOV_W'(mas_pkg::COV_LIMIT) : cfg.ncov;
   assign limit = (cfg.nlev > mas_pkg::NLEV_W'(mas_pkg::MAX_LEVELS))
                  ? mas_pkg::NLEV_W'(mas_pkg::MAX_LEVELS) : cfg.nlev;

   assign idx      = cnt_ff[mas_pkg::COV_IDX_W-1:0];
   assign cur_lev  = lev_ff[idx];
   assign row_addr = mas_pkg::ROW_ADDR_W'(cur_lev);
   assign cnt_next = cnt_ff + 1'b1;

   assign row  = rvalid_ff ? mem_rdata : '0;
   assign c0   = row[CB-1:0];
   assign c1   = row[2*CB-1:CB];
   assign diff = $signed({1'b0, c0}) - $signed({1'b0, c1});
   assign csel = arm_ff ? c1 : c0;
   assign cinc = (csel == mas_pkg::COUNT_MAX) ? csel : csel + 1'b1;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign best     = !score_ff[mas_pkg::SCORE_W-1];

   always_comb begin
      bad = 1'b0;
      for (int j = 0; j < mas_pkg::LEVEL_FIELDS; j++) begin
         if ((mas_pkg::NCOV_W'(j) < ncov) &&
             ({{(mas_pkg::NLEV_W-LW){1'b0}}, lev_ff[j]} >= limit)) begin
            bad = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      lev_in       = lev_ff;
      draw_in      = draw_ff;
      cnt_in       = cnt_ff;
      score_in     = score_ff;
      prod_in      = prod_ff;
      arm_in       = arm_ff;
      tie_in       = tie_ff;
      status_in    = status_ff;
      valid_in     = valid_ff;
      rvalid_in    = rvalid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_wdata    = arm_ff ? {cinc, c0} : {c1, cinc};

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tdata[mas_pkg::FUNC_W-1:0];
               for (int j = 0; j < mas_pkg::LEVEL_FIELDS; j++) begin
                  lev_in[j] = req_tdata[mas_pkg::FUNC_W + j*LW +: LW];
               end
               draw_in   = req_tdata[mas_pkg::FUNC_W + mas_pkg::LEVEL_FIELDS*LW +:
                                     mas_pkg::DRAW_W];
               arm_in    = 1'b0;
               tie_in    = 1'b0;
               status_in = 1'b0;
               case (req_tdata[mas_pkg::FUNC_W-1:0])
                  mas_pkg::FUNC_RECORD, mas_pkg::FUNC_ASSIGN: state_in = S_CHECK;
                  mas_pkg::FUNC_CLEAR: begin
                     valid_in = '0;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CHECK: begin
            cnt_in   = '0;
            score_in = '0;
            if (bad) begin
               status_in = 1'b1;
               state_in  = S_DONE;
            end else if (ncov == '0) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            rvalid_in = valid_ff[row_addr];
            state_in  = S_MUL;
         end
         S_MUL: begin
            prod_in  = mas_pkg::PROD_W'(diff * $signed({1'b0, cfg.weight[idx]}));
            state_in = S_ACC;
         end
         S_ACC: begin
            score_in = score_ff + mas_pkg::SCORE_W'(prod_ff);
            cnt_in   = cnt_next;
            state_in = (cnt_next == ncov) ? S_DECIDE : S_RD;
         end
         S_DECIDE: begin
            cnt_in = '0;
            if (score_ff == '0) begin
               tie_in = 1'b1;
               arm_in = ({1'b0, draw_ff} < cfg.tie_prob);
            end else begin
               arm_in = ({1'b0, draw_ff} < cfg.best_prob) ? best : !best;
            end
            state_in = ((func_ff == mas_pkg::FUNC_RECORD) && (ncov != '0)) ? S_WRD : S_DONE;
         end
         S_WRD: begin
            rvalid_in = valid_ff[row_addr];
            state_in  = S_WMOD;
         end
         S_WMOD: begin
            mem_we             = 1'b1;
            valid_in[row_addr] = 1'b1;
            cnt_in             = cnt_next;
            state_in           = (cnt_next == ncov) ? S_DONE : S_WRD;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {status_ff, tie_ff, arm_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      func_ff     <= func_in;
      lev_ff      <= lev_in;
      draw_ff     <= draw_in;
      cnt_ff      <= cnt_in;
      score_ff    <= score_in;
      prod_ff     <= prod_in;
      arm_ff      <= arm_in;
      tie_ff      <= tie_in;
      status_ff   <= status_in;
      rvalid_ff   <= rvalid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mas_pkg::RSP_DATA_W-mas_pkg::RSP_BITS){1'b0}}, rsp_data_ff};
   assign mem_raddr  = row_addr;
   assign mem_waddr  = row_addr;

endmodule

@@ sv/minimization_arm_assigner_core.sv @@
// Top level of the two-arm covariate minimization assigner.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata: func, level_0..level_3, random_draw
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: arm, was_tie, status
//   csr      in   csr_we                 csr_addr, csr_wdata
//
// An assign item reads, weighs and sums the count row of each covariate in use, then
// picks the arm; recording then rewrites those rows. One count table serves every
// read and write. A level out of range ends the item with status set; clear and
// unused codes go straight to the result; clear drops the per-row valid bits at once.
// Reset is synchronous; the count table reads as zero after reset, no sweep.
// A waiting result is held in the output register; a new item is taken meanwhile.
module minimization_arm_assigner_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] func, [7:2] level_0, [13:8] level_1, [19:14] level_2, [25:20] level_3,
   // [41:26] random_draw, [47:42] zero
   input  logic [mas_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] arm, [1] was_tie, [2] status, [7:3] zero
   output logic [mas_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [mas_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mas_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mas_pkg::cfg_type                  cfg;
   logic                              mem_we;
   logic [mas_pkg::ROW_ADDR_W-1:0]    mem_waddr;
   logic [mas_pkg::ROW_W-1:0]         mem_wdata;
   logic [mas_pkg::ROW_ADDR_W-1:0]    mem_raddr;
   logic [mas_pkg::ROW_W-1:0]         mem_rdata;

   mas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mas_ram #(
      .WIDTH (mas_pkg::ROW_W),
      .DEPTH (mas_pkg::MAX_LEVELS)
   ) u_counts (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   mas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

endmodule
